FILE: rtl/core/ipv4pv_pkg.sv
// ----------------------------------------------------------------------------
// ipv4pv_pkg
// Types and character constants shared by the IPv4:port string validator.
// ----------------------------------------------------------------------------
package ipv4pv_pkg;

    typedef logic [7:0]  char_t;
    typedef logic [31:0] addr_t;
    typedef logic [15:0] port_t;
    typedef logic [15:0] acc_t;
    typedef logic [19:0] acc_wide_t;
    typedef logic [2:0]  field_idx_t;
    typedef logic [2:0]  digit_cnt_t;
    typedef logic [23:0] octets_t;
    typedef logic [7:0]  octet_t;

    localparam char_t CHAR_ZERO  = 8'h30;
    localparam char_t CHAR_NINE  = 8'h39;
    localparam char_t CHAR_DOT   = 8'h2E;
    localparam char_t CHAR_COLON = 8'h3A;

    localparam acc_wide_t OCTET_MAX = 20'd255;
    localparam acc_wide_t PORT_MAX  = 20'd65535;

    localparam digit_cnt_t MAX_DIGITS = 3'd5;

    localparam field_idx_t FIELD_OCTET_D = 3'd3;
    localparam field_idx_t FIELD_PORT    = 3'd4;

endpackage

FILE: rtl/core/ipv4pv_char_if.sv
// ----------------------------------------------------------------------------
// ipv4pv_char_if
// Character request channel: one byte of address text, last byte flagged.
// ----------------------------------------------------------------------------
interface ipv4pv_char_if;

    logic                  valid;
    logic                  ready;
    ipv4pv_pkg::char_t     char_code;
    logic                  is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);

endinterface

FILE: rtl/core/ipv4pv_res_if.sv
// ----------------------------------------------------------------------------
// ipv4pv_res_if
// Result request channel: valid flag, packed address and port.
// ----------------------------------------------------------------------------
interface ipv4pv_res_if;

    logic                  valid;
    logic                  ready;
    logic                  valid_res;
    ipv4pv_pkg::addr_t     address;
    ipv4pv_pkg::port_t     port;

    modport source (output valid, output valid_res, output address, output port,
                    input ready);
    modport sink   (input valid, input valid_res, input address, input port,
                    output ready);

endinterface

FILE: rtl/core/ipv4_port_string_validator.sv
// ----------------------------------------------------------------------------
// ipv4_port_string_validator
// Strict A.B.C.D:P parser fed one character per request.
// ----------------------------------------------------------------------------
// Result path: an accepted last character is held in the input register, then
// parse logic loads the result register.
// Throughput: one character per cycle; a last character waits only while an
// earlier result is still held and not taken.
// Reset: rst_n asynchronously clears the parse state and both valid flags.
// ----------------------------------------------------------------------------
module ipv4_port_string_validator
(
    input  logic                 clk,
    input  logic                 rst_n,
    ipv4pv_char_if.sink          chars,
    ipv4pv_res_if.source         results
);

    // input stage
    logic                      in_valid_reg;
    ipv4pv_pkg::char_t         in_char_reg;
    logic                      in_last_reg;

    // parse state
    ipv4pv_pkg::field_idx_t    field_reg,  field_next;
    ipv4pv_pkg::acc_t          acc_reg,    acc_next;
    ipv4pv_pkg::digit_cnt_t    dcnt_reg,   dcnt_next;
    logic                      lzero_reg,  lzero_next;
    logic                      failed_reg, failed_next;
    ipv4pv_pkg::octets_t       octets_reg, octets_next;
    ipv4pv_pkg::octet_t        octd_reg,   octd_next;

    // result stage
    logic                      out_valid_reg;
    logic                      out_ok_reg,   out_ok_next;
    ipv4pv_pkg::addr_t         out_addr_reg, out_addr_next;
    ipv4pv_pkg::port_t         out_port_reg, out_port_next;

    // values after this byte, before end-of-string clearing
    ipv4pv_pkg::field_idx_t    tb_field;
    ipv4pv_pkg::acc_t          tb_acc;
    ipv4pv_pkg::digit_cnt_t    tb_dcnt;
    logic                      tb_lzero;
    logic                      tb_failed;
    ipv4pv_pkg::octets_t       tb_octets;
    ipv4pv_pkg::octet_t        tb_octd;

    logic                      is_digit;
    ipv4pv_pkg::acc_wide_t     digit_val;
    ipv4pv_pkg::acc_wide_t     acc_val;
    ipv4pv_pkg::acc_wide_t     acc_grow;
    ipv4pv_pkg::acc_wide_t     limit;
    logic                      advance;
    logic                      ok;

    // a non-last byte never waits on the result side
    assign advance     = in_valid_reg && (!in_last_reg || !out_valid_reg || results.ready);
    assign chars.ready = !in_valid_reg || advance;

    assign is_digit  = (in_char_reg >= ipv4pv_pkg::CHAR_ZERO) &&
                       (in_char_reg <= ipv4pv_pkg::CHAR_NINE);
    assign digit_val = {16'd0, in_char_reg[3:0]};
    assign acc_val   = {4'd0, acc_reg};
    assign acc_grow  = (dcnt_reg == '0) ? digit_val
                     : (acc_val << 3) + (acc_val << 1) + digit_val;
    assign limit     = (field_reg >= ipv4pv_pkg::FIELD_PORT) ? ipv4pv_pkg::PORT_MAX
                                                             : ipv4pv_pkg::OCTET_MAX;

    always_comb
    begin
        tb_field  = field_reg;
        tb_acc    = acc_reg;
        tb_dcnt   = dcnt_reg;
        tb_lzero  = lzero_reg;
        tb_failed = failed_reg;
        tb_octets = octets_reg;
        tb_octd   = octd_reg;
        if (!failed_reg)
        begin
            if (is_digit)
            begin
                if ((dcnt_reg != '0) && lzero_reg)
                begin
                    tb_failed = 1'b1;
                end
                else if ((dcnt_reg == ipv4pv_pkg::MAX_DIGITS) || (acc_grow > limit))
                begin
                    tb_failed = 1'b1;
                end
                else
                begin
                    if (dcnt_reg == '0)
                    begin
                        tb_lzero = (in_char_reg[3:0] == 4'd0);
                    end
                    tb_acc  = acc_grow[15:0];
                    tb_dcnt = dcnt_reg + 3'd1;
                end
            end
            else if (in_char_reg == ipv4pv_pkg::CHAR_DOT)
            begin
                if ((field_reg >= ipv4pv_pkg::FIELD_OCTET_D) || (dcnt_reg == '0))
                begin
                    tb_failed = 1'b1;
                end
                else
                begin
                    tb_octets = {octets_reg[15:0], acc_reg[7:0]};
                    tb_field  = field_reg + 3'd1;
                    tb_acc    = '0;
                    tb_dcnt   = '0;
                    tb_lzero  = 1'b0;
                end
            end
            else if (in_char_reg == ipv4pv_pkg::CHAR_COLON)
            begin
                if ((field_reg != ipv4pv_pkg::FIELD_OCTET_D) || (dcnt_reg == '0))
                begin
                    tb_failed = 1'b1;
                end
                else
                begin
                    tb_octd  = acc_reg[7:0];
                    tb_field = ipv4pv_pkg::FIELD_PORT;
                    tb_acc   = '0;
                    tb_dcnt  = '0;
                    tb_lzero = 1'b0;
                end
            end
            else
            begin
                tb_failed = 1'b1;
            end
        end
    end

    assign ok = !tb_failed && (tb_field == ipv4pv_pkg::FIELD_PORT) && (tb_dcnt != '0);

    always_comb
    begin
        field_next    = field_reg;
        acc_next      = acc_reg;
        dcnt_next     = dcnt_reg;
        lzero_next    = lzero_reg;
        failed_next   = failed_reg;
        octets_next   = octets_reg;
        octd_next     = octd_reg;
        out_ok_next   = out_ok_reg;
        out_addr_next = out_addr_reg;
        out_port_next = out_port_reg;
        if (advance)
        begin
            if (in_last_reg)
            begin
                // deliver and start over for the next string
                out_ok_next   = ok;
                out_addr_next = ok ? {tb_octets, tb_octd} : '0;
                out_port_next = ok ? tb_acc : '0;
                field_next    = '0;
                acc_next      = '0;
                dcnt_next     = '0;
                lzero_next    = 1'b0;
                failed_next   = 1'b0;
                octets_next   = '0;
                octd_next     = '0;
            end
            else
            begin
                field_next  = tb_field;
                acc_next    = tb_acc;
                dcnt_next   = tb_dcnt;
                lzero_next  = tb_lzero;
                failed_next = tb_failed;
                octets_next = tb_octets;
                octd_next   = tb_octd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            field_reg     <= '0;
            acc_reg       <= '0;
            dcnt_reg      <= '0;
            lzero_reg     <= 1'b0;
            failed_reg    <= 1'b0;
            octets_reg    <= '0;
            octd_reg      <= '0;
        end
        else
        begin
            if (chars.ready)
            begin
                in_valid_reg <= chars.valid;
            end
            if (advance && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            field_reg  <= field_next;
            acc_reg    <= acc_next;
            dcnt_reg   <= dcnt_next;
            lzero_reg  <= lzero_next;
            failed_reg <= failed_next;
            octets_reg <= octets_next;
            octd_reg   <= octd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            in_char_reg <= chars.char_code;
            in_last_reg <= chars.is_last;
        end
        out_ok_reg   <= out_ok_next;
        out_addr_reg <= out_addr_next;
        out_port_reg <= out_port_next;
    end

    assign results.valid     = out_valid_reg;
    assign results.valid_res = out_ok_reg;
    assign results.address   = out_addr_reg;
    assign results.port      = out_port_reg;

endmodule
